/* rtl/suffix_array_sort_engine_macros.svh */
// Assertion macros shared by the suffix array sort engine RTL.
// No dependencies; included by the modules that carry checks.
`ifndef SUFFIX_ARRAY_SORT_ENGINE_MACROS_SVH
`define SUFFIX_ARRAY_SORT_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define SASE_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("sase check failed");
`define SASE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sase check failed");
`else
`define SASE_ASSERT(label, clk, rst, cond)
`define SASE_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/sase_pkg.sv */
// Shared types and constants of the suffix array sort engine.
// No dependencies; imported by controller, datapath and top level.
package sase_pkg;

   localparam int unsigned DEF_MAX_CORPUS  = 64;
   localparam int unsigned DEF_SYMBOL_BITS = 20;
   localparam int unsigned POS_OUT_BITS    = 6;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_NEXT,
      ST_CHECK,
      ST_PREV_WAIT,
      ST_CMP_ISSUE,
      ST_CMP_EVAL,
      ST_SHIFT,
      ST_PLACE,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic sort_init;
      logic item_init;
      logic prev_rd;
      logic prev_cap;
      logic cmp_rd;
      logic cmp_step;
      logic shift;
      logic place;
      logic emit_init;
      logic emit_rd;
      logic emit_out;
      logic clear_len;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic i_done;
      logic j_zero;
      logic bound_hit;
      logic bound_before;
      logic sym_ne;
      logic sym_lt;
      logic sym_zero;
      logic first;
      logic tie_before;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage

/* rtl/sase_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sase_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port, registered read port that holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sase_ctrl.sv */
// Sequencer of the suffix array sort engine: load, insertion sort, emit.
// Depends on sase_pkg.
module sase_ctrl
   import sase_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.sort_init = 1'b1;
                  state_in      = ST_SORT_NEXT;
               end
            end
         end
         ST_SORT_NEXT: begin
            if (status.i_done) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT_RD;
            end else begin
               cmd.item_init = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.j_zero) begin
               state_in = ST_PLACE;
            end else begin
               cmd.prev_rd = 1'b1;
               state_in    = ST_PREV_WAIT;
            end
         end
         ST_PREV_WAIT: begin
            cmd.prev_cap = 1'b1;
            state_in     = ST_CMP_ISSUE;
         end
         ST_CMP_ISSUE: begin
            if (status.bound_hit) begin
               state_in = status.bound_before ? ST_SHIFT : ST_PLACE;
            end else begin
               cmd.cmp_rd = 1'b1;
               state_in   = ST_CMP_EVAL;
            end
         end
         ST_CMP_EVAL: begin
            if (status.sym_ne) begin
               state_in = status.sym_lt ? ST_SHIFT : ST_PLACE;
            end else if (!status.first && status.sym_zero) begin
               state_in = status.tie_before ? ST_SHIFT : ST_PLACE;
            end else begin
               cmd.cmp_step = 1'b1;
               state_in     = ST_CMP_ISSUE;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_SORT_NEXT;
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (status.out_free) begin
               cmd.emit_out = 1'b1;
               if (status.emit_last) begin
                  cmd.clear_len = 1'b1;
                  state_in      = ST_LOAD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

/* rtl/sase_dpath.sv */
// Datapath of the suffix array sort engine: corpus and order RAMs, counters,
// suffix comparator and output register. Depends on sase_pkg, sase_ram, macros.
`include "suffix_array_sort_engine_macros.svh"
module sase_dpath
   import sase_pkg::*;
#(
   parameter int unsigned MAX_CORPUS  = DEF_MAX_CORPUS,
   parameter int unsigned SYMBOL_BITS = DEF_SYMBOL_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [SYMBOL_BITS-1:0]  symbol,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output logic [POS_OUT_BITS-1:0] rsp_position,
   output logic                    rsp_tlast
);

   localparam int unsigned PW = $clog2(MAX_CORPUS);
   localparam int unsigned LW = $clog2(MAX_CORPUS + 1);
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_CORPUS);
   localparam logic [LW-1:0] ONE     = LW'(1);

   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] i_ff, i_in, j_ff, j_in, p_ff, p_in, q_ff, q_in, k_ff, k_in;
   logic [PW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic          first_ff, first_in;
   logic          out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [PW-1:0] out_pos_ff, out_pos_in;

   logic                   corpus_wr;
   logic [SYMBOL_BITS-1:0] sym_p, sym_q;
   logic                   order_wr;
   logic [PW-1:0]          order_wr_addr, order_wr_data, order_rd_addr, order_rd;
   logic [LW-1:0]          j_dec;

   assign j_dec     = j_ff - ONE;
   assign corpus_wr = cmd.load && (len_ff < MAX_LEN);

   // two corpus copies so both suffixes are read in the same cycle
   sase_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_CORPUS)) u_corpus_p (
      .clock(clock), .wr_en(corpus_wr), .wr_addr(len_ff[PW-1:0]), .wr_data(symbol),
      .rd_en(cmd.cmp_rd), .rd_addr(p_ff[PW-1:0]), .rd_data(sym_p)
   );
   sase_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_CORPUS)) u_corpus_q (
      .clock(clock), .wr_en(corpus_wr), .wr_addr(len_ff[PW-1:0]), .wr_data(symbol),
      .rd_en(cmd.cmp_rd), .rd_addr(q_ff[PW-1:0]), .rd_data(sym_q)
   );

   // order store: shift or place at j, read at j-1 or k
   assign order_wr      = cmd.shift || cmd.place;
   assign order_wr_addr = j_ff[PW-1:0];
   assign order_wr_data = cmd.shift ? prev_ff : cur_ff;
   assign order_rd_addr = cmd.emit_rd ? k_ff[PW-1:0] : j_dec[PW-1:0];

   sase_ram #(.WIDTH(PW), .DEPTH(MAX_CORPUS)) u_order (
      .clock(clock), .wr_en(order_wr), .wr_addr(order_wr_addr), .wr_data(order_wr_data),
      .rd_en(cmd.prev_rd || cmd.emit_rd), .rd_addr(order_rd_addr), .rd_data(order_rd)
   );

   // status towards the controller
   always_comb begin
      status.i_done       = (i_ff == len_ff);
      status.j_zero       = (j_ff == '0);
      status.bound_hit    = (p_ff >= len_ff) || (q_ff >= len_ff);
      status.bound_before = ((p_ff >= len_ff) && (q_ff >= len_ff)) ? (cur_ff < prev_ff)
                                                                   : (p_ff >= len_ff);
      status.sym_ne       = (sym_p != sym_q);
      status.sym_lt       = (sym_p < sym_q);
      status.sym_zero     = (sym_p == '0);
      status.first        = first_ff;
      status.tie_before   = (cur_ff < prev_ff);
      status.emit_last    = ((k_ff + ONE) == len_ff);
      status.out_free     = !out_valid_ff || rsp_tready;
   end

   // next values of counters and working registers
   always_comb begin
      len_in       = len_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_last_in  = out_last_ff;
      out_pos_in   = out_pos_ff;
      if (corpus_wr) begin
         len_in = len_ff + ONE;
      end
      if (cmd.sort_init) begin
         i_in = '0;
      end
      if (cmd.item_init) begin
         cur_in = i_ff[PW-1:0];
         j_in   = i_ff;
      end
      if (cmd.prev_cap) begin
         prev_in  = order_rd;
         p_in     = LW'(cur_ff);
         q_in     = LW'(order_rd);
         first_in = 1'b1;
      end
      if (cmd.cmp_step) begin
         p_in     = p_ff + ONE;
         q_in     = q_ff + ONE;
         first_in = 1'b0;
      end
      if (cmd.shift) begin
         j_in = j_dec;
      end
      if (cmd.place) begin
         i_in = i_ff + ONE;
      end
      if (cmd.emit_init) begin
         k_in = '0;
      end
      if (cmd.emit_out) begin
         out_valid_in = 1'b1;
         out_pos_in   = order_rd;
         out_last_in  = status.emit_last;
         k_in         = k_ff + ONE;
      end
      if (cmd.clear_len) begin
         len_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      first_ff    <= first_in;
      out_last_ff <= out_last_in;
      out_pos_ff  <= out_pos_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_position = POS_OUT_BITS'(out_pos_ff);
   assign rsp_tlast    = out_last_ff;

   // the final item clears the length, so only earlier items are range checked
   `SASE_ASSERT(a_len_bound, clock, reset, len_ff <= MAX_LEN)
   `SASE_ASSERT_IMP(a_emit_in_range, clock, reset, cmd.emit_out && !status.emit_last, LW'(out_pos_ff) < len_ff)
   `SASE_ASSERT_IMP(a_shift_nonzero, clock, reset, cmd.shift, j_ff < i_ff)

endmodule

/* rtl/suffix_array_sort_engine.sv */
// Suffix array sort engine: takes one corpus symbol per item (symbol 0 ends a
// sentence) and, after the item flagged tlast, emits every start position in
// suffix order, the final one flagged by tlast. Symbols load at one item per
// cycle; symbols beyond MAX_CORPUS are dropped. The sort is an insertion sort
// over an order RAM, one symbol pair at a time from duplicated corpus RAMs, so
// its length is data dependent, roughly N*N/2 comparisons at worst.
// Emission reads each position from the order RAM, then registers it once the
// output is free. No item is taken while sorting or emitting. Depends on
// sase_pkg, sase_ctrl, sase_dpath and the macro header.
module suffix_array_sort_engine
   import sase_pkg::*;
#(
   parameter int unsigned MAX_CORPUS  = DEF_MAX_CORPUS,
   parameter int unsigned SYMBOL_BITS = DEF_SYMBOL_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SYMBOL_BITS + 7) / 8)*8-1:0] req_tdata,  // symbol
   input  logic                                 req_tlast,  // last_symbol
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,  // suffix_position
   output logic                                 rsp_tlast   // last_position
);

   cmd_type                 cmd;
   status_type              status;
   logic [POS_OUT_BITS-1:0] position;

   sase_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tlast(req_tlast), .req_tready(req_tready),
      .status(status), .cmd(cmd)
   );

   sase_dpath #(.MAX_CORPUS(MAX_CORPUS), .SYMBOL_BITS(SYMBOL_BITS)) u_dpath (
      .clock(clock), .reset(reset),
      .symbol(req_tdata[SYMBOL_BITS-1:0]),
      .cmd(cmd), .status(status),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid),
      .rsp_position(position), .rsp_tlast(rsp_tlast)
   );

   assign rsp_tdata = 8'(position);

endmodule

/* tb/sv/suffix_array_sort_engine_tb.sv */
// Self-checking bench for the suffix array sort engine: streams short corpora,
// predicts the sorted start positions and checks each result item in order.
// Depends on sase_pkg and the suffix_array_sort_engine RTL.
`timescale 1ns / 100ps

module suffix_array_sort_engine_tb
   import sase_pkg::*;
;

   localparam int CORPUS_DEPTH = DEF_MAX_CORPUS;
   localparam int SYM_W        = DEF_SYMBOL_BITS;
   localparam int REQ_W        = ((SYM_W + 7) / 8) * 8;

   typedef struct packed {
      logic [POS_OUT_BITS-1:0] position;
      logic                    last_pos;
   } sorted_pos_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;  // symbol
   logic             req_tlast = 1'b0; // last_symbol
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;        // suffix_position
   logic             rsp_tlast;        // last_position

   sorted_pos_type   sorted_q[$];
   logic [SYM_W-1:0] corpus_sym[CORPUS_DEPTH];
   int               corpus_len = 0;
   int               fail_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               recv_hold = 0;

   suffix_array_sort_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // true when the suffix at a sorts strictly ahead of the one at b
   function automatic bit suffix_precedes(int a, int b);
      int  p;
      int  q;
      bit  first_sym;
      p = a;
      q = b;
      first_sym = 1'b1;
      while (p < corpus_len && q < corpus_len) begin
         if (corpus_sym[p] != corpus_sym[q]) return corpus_sym[p] < corpus_sym[q];
         if (!first_sym && corpus_sym[p] == '0) return a < b;
         p++;
         q++;
         first_sym = 1'b0;
      end
      if (p >= corpus_len && q >= corpus_len) return a < b;
      return p >= corpus_len;
   endfunction

   // insertion sort over start positions, then queue the sorted order
   task automatic queue_sorted_positions();
      int order[CORPUS_DEPTH];
      int j;
      sorted_pos_type e;
      for (int i = 0; i < corpus_len; i++) begin
         j = i;
         while (j > 0 && suffix_precedes(i, order[j-1])) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = i;
      end
      for (int k = 0; k < corpus_len; k++) begin
         e.position = order[k][POS_OUT_BITS-1:0];
         e.last_pos = (k == corpus_len - 1);
         sorted_q.push_back(e);
      end
      corpus_len = 0;
   endtask

   // offer one item, hold until accepted, then update the prediction
   task automatic send_symbol(input logic [SYM_W-1:0] sym, input bit last_sym);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(sym);
      req_tlast  <= last_sym;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (corpus_len < CORPUS_DEPTH) begin
         corpus_sym[corpus_len] = sym;
         corpus_len++;
      end
      if (last_sym) queue_sorted_positions();
   endtask

   task automatic send_corpus(input logic [SYM_W-1:0] syms[$]);
      foreach (syms[i]) send_symbol(syms[i], i == syms.size() - 1);
   endtask

   // small alphabet with plenty of sentence ends, now and then a full-width symbol
   function automatic logic [SYM_W-1:0] pick_symbol();
      case ($urandom_range(3))
         0:       return '0;
         3:       return SYM_W'($urandom);
         default: return SYM_W'($urandom_range(1, 3));
      endcase
   endfunction

   task automatic send_random_corpus(input int len);
      logic [SYM_W-1:0] syms[$];
      for (int i = 0; i < len; i++) syms.push_back(pick_symbol());
      send_corpus(syms);
   endtask

   // check each result item against the oldest prediction; drive tready
   initial begin
      sorted_pos_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (sorted_q.size() == 0) begin
               $error("unexpected result item: suffix_position %0d", rsp_tdata[5:0]);
               fail_count++;
            end else begin
               e = sorted_q.pop_front();
               if (rsp_tdata[POS_OUT_BITS-1:0] !== e.position) begin
                  $error("suffix_position expected %0d actual %0d", e.position,
                         rsp_tdata[POS_OUT_BITS-1:0]);
                  fail_count++;
               end
               if (rsp_tlast !== e.last_pos) begin
                  $error("last_position expected %0d actual %0d", e.last_pos, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // extremes, sentence ends, runs to the corpus end and tied suffixes
   task automatic test_directed();
      send_corpus('{20'hFFFFF});
      send_corpus('{20'hFFFFF, 20'h0, 20'hFFFFF, 20'h0});
      send_corpus('{20'h0, 20'h0, 20'h0});
      send_corpus('{20'h5, 20'h5, 20'h5, 20'h5});
      send_corpus('{20'h1, 20'h2, 20'h0, 20'h1, 20'h2, 20'h0});
      send_corpus('{20'h3, 20'hAAAAA, 20'h55555, 20'h80000, 20'h1});
   endtask

   task automatic test_random(input int n_items, input int s_pct, input int r_pct);
      int sent;
      int len;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(16, 28) : $urandom_range(1, 8);
         send_random_corpus(len);
         sent += len;
      end
   endtask

   // fill past capacity so the extra symbols drop and tlast arrives when full
   task automatic test_overflow();
      send_random_corpus(CORPUS_DEPTH + 4);
   endtask

   // stall the receiver long enough for the block to stop taking items
   task automatic test_backpressure();
      recv_hold = 600;
      send_random_corpus(6);
      send_random_corpus(6);
      send_random_corpus(4);
   endtask

   // let the block drain completely before the next corpus
   task automatic test_drain_pause();
      send_random_corpus(5);
      req_tvalid <= 1'b0;
      wait (sorted_q.size() == 0);
      @(posedge clock);
      send_random_corpus(5);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(35, 18, 74);
      test_backpressure();
      test_random(35, 74, 18);
      test_drain_pause();
      test_random(25, 0, 0);
      test_overflow();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      wait (sorted_q.size() == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && sorted_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule
